// ----- rtl/bounded_indexed_list_assert.svh -----
// assertion macros shared by the bounded indexed list checker
`ifndef BOUNDED_INDEXED_LIST_ASSERT_SVH
`define BOUNDED_INDEXED_LIST_ASSERT_SVH

// condition holds at every edge outside reset
`define BLC_ASSERT_ALWAYS(name, expr, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (expr)) else $error(msg);

// consequent holds in the same cycle as the trigger
`define BLC_ASSERT_IMPLIES(name, pre, post, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error(msg);

// consequent holds in the cycle after the trigger
`define BLC_ASSERT_NEXT(name, pre, post, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error(msg);

`endif

// ----- rtl/blc_pkg.sv -----
// shared types, codes and field layout of the bounded indexed list
package blc_pkg;

   // default sizes
   localparam int unsigned DEF_DEPTH      = 16;
   localparam int unsigned DEF_DATA_WIDTH = 32;
   localparam int unsigned DEF_IDX_W      = $clog2(DEF_DEPTH);
   localparam int unsigned DEF_CNT_W      = $clog2(DEF_DEPTH + 1);

   // request fields
   localparam int unsigned OP_W        = 4;
   localparam int unsigned POS_W       = 5;
   localparam int unsigned DIN_W       = 32;
   localparam int unsigned OP_LSB      = 0;
   localparam int unsigned POS_LSB     = OP_LSB + OP_W;
   localparam int unsigned DIN_LSB     = POS_LSB + POS_W;
   localparam int unsigned REQ_TDATA_W = 48;

   // response fields
   localparam int unsigned DOUT_W      = 32;
   localparam int unsigned CNT_W       = 5;
   localparam int unsigned STAT_W      = 2;
   localparam int unsigned DOUT_LSB    = 0;
   localparam int unsigned FRONT_LSB   = DOUT_LSB + DOUT_W;
   localparam int unsigned BACK_LSB    = FRONT_LSB + DOUT_W;
   localparam int unsigned CNT_LSB     = BACK_LSB + DOUT_W;
   localparam int unsigned EMPTY_LSB   = CNT_LSB + CNT_W;
   localparam int unsigned STAT_LSB    = EMPTY_LSB + 1;
   localparam int unsigned RSP_TDATA_W = 104;

   // operation codes
   localparam logic [OP_W-1:0] OP_PUSH_FRONT = 4'd0;
   localparam logic [OP_W-1:0] OP_POP_FRONT  = 4'd1;
   localparam logic [OP_W-1:0] OP_PUSH_BACK  = 4'd2;
   localparam logic [OP_W-1:0] OP_POP_BACK   = 4'd3;
   localparam logic [OP_W-1:0] OP_INSERT     = 4'd4;
   localparam logic [OP_W-1:0] OP_ERASE      = 4'd5;
   localparam logic [OP_W-1:0] OP_READ       = 4'd6;
   localparam logic [OP_W-1:0] OP_READ_END   = 4'd7;
   localparam logic [OP_W-1:0] OP_REMOVE     = 4'd8;
   localparam logic [OP_W-1:0] OP_REVERSE    = 4'd9;

   // status codes
   localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
   localparam logic [STAT_W-1:0] ST_RANGE   = 2'd1;
   localparam logic [STAT_W-1:0] ST_FULL    = 2'd2;
   localparam logic [STAT_W-1:0] ST_MISSING = 2'd3;

   // cell actions
   localparam logic [1:0] ACT_HOLD   = 2'd0;
   localparam logic [1:0] ACT_INSERT = 2'd1;
   localparam logic [1:0] ACT_DELETE = 2'd2;
   localparam logic [1:0] ACT_SWAP   = 2'd3;

   // broadcast command to the cell row at default sizes
   typedef struct packed {
      logic [1:0]                action;
      logic [DEF_IDX_W-1:0]      key;
      logic [DEF_CNT_W-1:0]      count;
      logic                      phase;
      logic                      match_mode;
      logic [DEF_DATA_WIDTH-1:0] value;
   } cell_cmd_type;

   // lookup tap passed toward the front at default sizes
   typedef struct packed {
      logic                      hit;
      logic [DEF_IDX_W-1:0]      idx;
      logic [DEF_DATA_WIDTH-1:0] value;
   } cell_tap_type;

endpackage

// ----- rtl/blc_cell.sv -----
// one storage cell of the list row with its lookup tap stages
module blc_cell #(
   parameter int unsigned CELL_INDEX = 0,
   parameter int unsigned DATA_WIDTH = blc_pkg::DEF_DATA_WIDTH,
   parameter int unsigned IDX_WIDTH  = blc_pkg::DEF_IDX_W,
   parameter type         cmd_type   = blc_pkg::cell_cmd_type,
   parameter type         tap_type   = blc_pkg::cell_tap_type
) (
   input  logic                  clock,
   input  cmd_type               cmd,
   input  logic [DATA_WIDTH-1:0] left_value,
   input  logic [DATA_WIDTH-1:0] right_value,
   input  tap_type               tap_from_right,
   input  logic [DATA_WIDTH-1:0] prev_from_right,
   output logic [DATA_WIDTH-1:0] value,
   output tap_type               tap_out,
   output logic [DATA_WIDTH-1:0] prev_out
);
   import blc_pkg::*;

   localparam logic [IDX_WIDTH-1:0] MY_IDX = IDX_WIDTH'(CELL_INDEX);
   localparam logic                 ODD    = 1'(CELL_INDEX % 2);

   logic [DATA_WIDTH-1:0] value_ff, value_in;
   tap_type               tap_ff, tap_in;
   logic [DATA_WIDTH-1:0] prev_ff, prev_in;
   logic [31:0]           cnt_w, key_w;
   logic                  active, has_right, hit;

   assign cnt_w     = 32'(cmd.count);
   assign key_w     = 32'(cmd.key);
   assign active    = CELL_INDEX < cnt_w;
   assign has_right = (CELL_INDEX + 1) < cnt_w;

   // next stored value from own, neighbor or broadcast data
   always_comb begin
      value_in = value_ff;
      unique case (cmd.action)
         ACT_INSERT: begin
            if (key_w == CELL_INDEX) begin
               value_in = cmd.value;
            end else if (key_w < CELL_INDEX) begin
               value_in = left_value;
            end
         end
         ACT_DELETE: begin
            if (key_w <= CELL_INDEX) begin
               value_in = right_value;
            end
         end
         ACT_SWAP: begin
            // odd-even transposition round, every pair in the list swaps
            if (active) begin
               if (ODD == cmd.phase) begin
                  if (has_right) begin
                     value_in = right_value;
                  end
               end else if (CELL_INDEX != 0) begin
                  value_in = left_value;
               end
            end
         end
         default: begin
            value_in = value_ff;
         end
      endcase
   end

   // lookup taps: a hit here overrides whatever comes from further back
   assign hit = cmd.match_mode ? (active && (value_ff == cmd.value)) : (key_w == CELL_INDEX);

   always_comb begin
      tap_in = tap_from_right;
      if (hit) begin
         tap_in.hit   = 1'b1;
         tap_in.idx   = MY_IDX;
         tap_in.value = value_ff;
      end
   end

   // second-to-last element tap
   assign prev_in = ((CELL_INDEX + 2) == cnt_w) ? value_ff : prev_from_right;

   always_ff @(posedge clock) begin
      value_ff <= value_in;
      tap_ff   <= tap_in;
      prev_ff  <= prev_in;
   end

   assign value    = value_ff;
   assign tap_out  = tap_ff;
   assign prev_out = prev_ff;

endmodule

// ----- rtl/bounded_indexed_list.sv -----
// top level of the bounded indexed list
//
// Ordered list of up to DEPTH words held in a row of cells, cell 0 the front.
// One transaction is worked at a time. An op is accepted, then the lookup
// taps ripple in the scan state from the far end of the row to cell 0
// (indexed read, first equal value and the second-to-last element), then
// the apply state does the shift or write and the done state loads the
// response register once it is free. Reverse on two or more elements adds
// one odd-even swap round per element held. The next request is taken while
// a response still waits in the output register.
module bounded_indexed_list #(
   parameter int unsigned DEPTH      = blc_pkg::DEF_DEPTH,
   parameter int unsigned DATA_WIDTH = blc_pkg::DEF_DATA_WIDTH
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // op[3:0], position[8:4], data_in[40:9], zero pad[47:41]
   input  logic [blc_pkg::REQ_TDATA_W-1:0]  req_tdata,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // data_out[31:0], front_value[63:32], back_value[95:64], count[100:96],
   // is_empty[101], status[103:102]
   output logic [blc_pkg::RSP_TDATA_W-1:0]  rsp_tdata
);
   import blc_pkg::*;

   localparam int unsigned IW = $clog2(DEPTH);
   localparam int unsigned CW = $clog2(DEPTH + 1);
   localparam int unsigned PW = (CW > POS_W) ? CW : POS_W;

   typedef struct packed {
      logic [1:0]            action;
      logic [IW-1:0]         key;
      logic [CW-1:0]         count;
      logic                  phase;
      logic                  match_mode;
      logic [DATA_WIDTH-1:0] value;
   } cmd_type;

   typedef struct packed {
      logic                  hit;
      logic [IW-1:0]         idx;
      logic [DATA_WIDTH-1:0] value;
   } tap_type;

   // sequencer states
   localparam logic [2:0] S_IDLE    = 3'd0;
   localparam logic [2:0] S_SCAN    = 3'd1;
   localparam logic [2:0] S_APPLY   = 3'd2;
   localparam logic [2:0] S_REVERSE = 3'd3;
   localparam logic [2:0] S_DONE    = 3'd4;

   logic [2:0]             state_ff, state_in;
   logic [IW-1:0]          ctr_ff, ctr_in;
   logic [CW-1:0]          count_ff, count_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [OP_W-1:0]        op_ff, op_in;
   logic [POS_W-1:0]       pos_ff, pos_in;
   logic [DATA_WIDTH-1:0]  key_ff, key_in;
   logic [DATA_WIDTH-1:0]  back_ff, back_in;
   logic [DATA_WIDTH-1:0]  dout_ff, dout_in;
   logic [STAT_W-1:0]      status_ff, status_in;
   logic [RSP_TDATA_W-1:0] rsp_data_ff, rsp_data_in;

   logic [DATA_WIDTH-1:0]  cell_value [DEPTH];
   tap_type                tap_q [DEPTH];
   logic [DATA_WIDTH-1:0]  prev_q [DEPTH];
   cmd_type                cmd;

   logic [PW-1:0]          pos_x, cnt_x, last_x, tgt_x;
   logic                   full, empty, rsp_free;
   logic [1:0]             act;
   logic [IW-1:0]          act_key;
   logic [STAT_W-1:0]      st;
   logic [DATA_WIDTH-1:0]  dout, nback;
   logic                   go_rev;
   logic [DATA_WIDTH-1:0]  front_out, back_out;

   assign pos_x  = PW'(pos_ff);
   assign cnt_x  = PW'(count_ff);
   assign last_x = cnt_x - PW'(1);
   assign full   = (count_ff == CW'(DEPTH));
   assign empty  = (count_ff == '0);

   // scan target: direct index or counted from the end
   always_comb begin
      tgt_x = pos_x;
      if (op_ff == OP_READ_END) begin
         tgt_x = cnt_x - pos_x;
      end
   end

   // op decision once the taps have settled at cell 0
   always_comb begin
      act     = ACT_HOLD;
      act_key = '0;
      st      = ST_OK;
      dout    = '0;
      nback   = back_ff;
      go_rev  = 1'b0;
      case (op_ff)
         OP_PUSH_FRONT: begin
            if (full) begin
               st = ST_FULL;
            end else begin
               act = ACT_INSERT;
               if (empty) begin
                  nback = key_ff;
               end
            end
         end
         OP_POP_FRONT: begin
            if (empty) begin
               st = ST_RANGE;
            end else begin
               act  = ACT_DELETE;
               dout = cell_value[0];
            end
         end
         OP_PUSH_BACK: begin
            if (full) begin
               st = ST_FULL;
            end else begin
               act     = ACT_INSERT;
               act_key = count_ff[IW-1:0];
               nback   = key_ff;
            end
         end
         OP_POP_BACK: begin
            if (empty) begin
               st = ST_RANGE;
            end else begin
               act     = ACT_DELETE;
               act_key = last_x[IW-1:0];
               dout    = back_ff;
               nback   = prev_q[0];
            end
         end
         OP_INSERT: begin
            if (pos_x > cnt_x) begin
               st = ST_RANGE;
            end else if (full) begin
               st = ST_FULL;
            end else begin
               act     = ACT_INSERT;
               act_key = pos_x[IW-1:0];
               if (pos_x == cnt_x) begin
                  nback = key_ff;
               end
            end
         end
         OP_ERASE: begin
            if (pos_x >= cnt_x) begin
               st = ST_RANGE;
            end else begin
               act     = ACT_DELETE;
               act_key = pos_x[IW-1:0];
               dout    = tap_q[0].value;
               if (pos_x == last_x) begin
                  nback = prev_q[0];
               end
            end
         end
         OP_READ: begin
            if (pos_x >= cnt_x) begin
               st = ST_RANGE;
            end else begin
               dout = tap_q[0].value;
            end
         end
         OP_READ_END: begin
            if ((pos_x == '0) || (pos_x > cnt_x)) begin
               st = ST_RANGE;
            end else begin
               dout = tap_q[0].value;
            end
         end
         OP_REMOVE: begin
            if (empty) begin
               st = ST_RANGE;
            end else if (!tap_q[0].hit) begin
               st = ST_MISSING;
            end else begin
               act     = ACT_DELETE;
               act_key = tap_q[0].idx;
               dout    = tap_q[0].value;
               if (tap_q[0].idx == last_x[IW-1:0]) begin
                  nback = prev_q[0];
               end
            end
         end
         OP_REVERSE: begin
            nback  = cell_value[0];
            go_rev = (cnt_x > PW'(1));
         end
         default: begin
            st = ST_OK;
         end
      endcase
   end

   // command broadcast to the row
   always_comb begin
      cmd.action     = ACT_HOLD;
      cmd.key        = tgt_x[IW-1:0];
      cmd.count      = count_ff;
      cmd.phase      = ctr_ff[0];
      cmd.match_mode = (op_ff == OP_REMOVE);
      cmd.value      = key_ff;
      if (state_ff == S_APPLY) begin
         cmd.action = act;
         cmd.key    = act_key;
      end else if (state_ff == S_REVERSE) begin
         cmd.action = ACT_SWAP;
      end
   end

   // the cell row
   for (genvar g = 0; g < DEPTH; g++) begin : g_cell
      logic [DATA_WIDTH-1:0] left_v, right_v, prev_r;
      tap_type               tap_r;

      if (g == 0) begin : g_first
         assign left_v = '0;
      end else begin : g_inner_left
         assign left_v = cell_value[g-1];
      end

      if (g == DEPTH - 1) begin : g_last
         assign right_v = '0;
         assign tap_r   = '0;
         assign prev_r  = '0;
      end else begin : g_inner_right
         assign right_v = cell_value[g+1];
         assign tap_r   = tap_q[g+1];
         assign prev_r  = prev_q[g+1];
      end

      blc_cell #(
         .CELL_INDEX (g),
         .DATA_WIDTH (DATA_WIDTH),
         .IDX_WIDTH  (IW),
         .cmd_type   (cmd_type),
         .tap_type   (tap_type)
      ) u_cell (
         .clock           (clock),
         .cmd             (cmd),
         .left_value      (left_v),
         .right_value     (right_v),
         .tap_from_right  (tap_r),
         .prev_from_right (prev_r),
         .value           (cell_value[g]),
         .tap_out         (tap_q[g]),
         .prev_out        (prev_q[g])
      );
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_free   = !rsp_valid_ff || rsp_tready;
   assign front_out  = empty ? '0 : cell_value[0];
   assign back_out   = empty ? '0 : back_ff;

   // sequencer next state
   always_comb begin
      state_in     = state_ff;
      ctr_in       = ctr_ff;
      count_in     = count_ff;
      rsp_valid_in = rsp_valid_ff;
      op_in        = op_ff;
      pos_in       = pos_ff;
      key_in       = key_ff;
      back_in      = back_ff;
      dout_in      = dout_ff;
      status_in    = status_ff;
      rsp_data_in  = rsp_data_ff;

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               op_in    = req_tdata[OP_LSB +: OP_W];
               pos_in   = req_tdata[POS_LSB +: POS_W];
               key_in   = DATA_WIDTH'(req_tdata[DIN_LSB +: DIN_W]);
               ctr_in   = '0;
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            if (ctr_ff == IW'(DEPTH - 1)) begin
               state_in = S_APPLY;
            end else begin
               ctr_in = ctr_ff + 1'b1;
            end
         end
         S_APPLY: begin
            dout_in   = dout;
            status_in = st;
            back_in   = nback;
            ctr_in    = '0;
            if (act == ACT_INSERT) begin
               count_in = count_ff + 1'b1;
            end else if (act == ACT_DELETE) begin
               count_in = count_ff - 1'b1;
            end
            state_in = go_rev ? S_REVERSE : S_DONE;
         end
         S_REVERSE: begin
            if (ctr_ff == last_x[IW-1:0]) begin
               state_in = S_DONE;
            end else begin
               ctr_in = ctr_ff + 1'b1;
            end
         end
         S_DONE: begin
            if (rsp_free) begin
               rsp_data_in = '0;
               rsp_data_in[DOUT_LSB +: DOUT_W]   = DOUT_W'(dout_ff);
               rsp_data_in[FRONT_LSB +: DOUT_W]  = DOUT_W'(front_out);
               rsp_data_in[BACK_LSB +: DOUT_W]   = DOUT_W'(back_out);
               rsp_data_in[CNT_LSB +: CNT_W]     = CNT_W'(count_ff);
               rsp_data_in[EMPTY_LSB]            = empty;
               rsp_data_in[STAT_LSB +: STAT_W]   = status_ff;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         ctr_ff       <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ctr_ff       <= ctr_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      pos_ff      <= pos_in;
      key_ff      <= key_in;
      back_ff     <= back_in;
      dout_ff     <= dout_in;
      status_ff   <= status_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

// ----- rtl/blc_checker.sv -----
// port-level checks of the bounded indexed list and their binding
`include "bounded_indexed_list_assert.svh"

module blc_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_tvalid,
   input logic                            req_tready,
   input logic                            rsp_tvalid,
   input logic [blc_pkg::RSP_TDATA_W-1:0] rsp_tdata
);
   import blc_pkg::*;

   logic [DOUT_W-1:0] rsp_dout, rsp_front, rsp_back;
   logic [CNT_W-1:0]  rsp_count;
   logic              rsp_empty;
   logic [STAT_W-1:0] rsp_status;

   // response fields
   assign rsp_dout   = rsp_tdata[DOUT_LSB +: DOUT_W];
   assign rsp_front  = rsp_tdata[FRONT_LSB +: DOUT_W];
   assign rsp_back   = rsp_tdata[BACK_LSB +: DOUT_W];
   assign rsp_count  = rsp_tdata[CNT_LSB +: CNT_W];
   assign rsp_empty  = rsp_tdata[EMPTY_LSB];
   assign rsp_status = rsp_tdata[STAT_LSB +: STAT_W];

   // the empty flag agrees with the reported count
   `BLC_ASSERT_IMPLIES(a_empty_flag, rsp_tvalid, rsp_empty == (rsp_count == '0), "empty flag and count disagree")

   // an empty list reports zero at both ends
   `BLC_ASSERT_IMPLIES(a_empty_ends, rsp_tvalid && rsp_empty, (rsp_front == '0) && (rsp_back == '0), "empty list shows a front or back value")

   // a failed op returns no data
   `BLC_ASSERT_ALWAYS(a_fail_no_data, !(rsp_tvalid && (rsp_status != ST_OK) && (rsp_dout != '0)), "failed transaction carries data")

   // only one request is worked at a time
   `BLC_ASSERT_NEXT(a_one_in_flight, req_tvalid && req_tready, !req_tready, "request taken while another is in flight")

endmodule

bind bounded_indexed_list blc_checker u_blc_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tdata  (rsp_tdata)
);

// ----- bench/tb_bounded_indexed_list.sv -----
// self-checking testbench for the bounded indexed list: list predictor, random ops, stream stalls
module tb_bounded_indexed_list;
   timeunit 1ns;
   timeprecision 1ps;

   import blc_pkg::*;

   localparam int unsigned LIST_DEPTH     = DEF_DEPTH;
   localparam int unsigned CLOCK_PERIOD   = 10;
   localparam int unsigned RESET_CYCLES   = 9;
   localparam int unsigned RANDOM_ITEMS   = 1625;
   localparam int unsigned PHASE_ITEMS    = 40;
   localparam int unsigned HOLD_ITEM      = 400;
   localparam int unsigned HOLD_CYCLES    = 400;
   localparam int unsigned WATCHDOG_LIMIT = 5000;
   localparam int unsigned DRAIN_CYCLES   = 2 * (2 * DEF_DEPTH + 3);
   localparam int unsigned MAX_REPORTS    = 10;
   localparam int unsigned POOL_SIZE      = 8;

   // codes outside the defined op set, ignored by the block
   localparam logic [OP_W-1:0] OP_FIRST_UNUSED = 4'd10;
   localparam logic [OP_W-1:0] OP_LAST_UNUSED  = 4'd15;

   // traffic mix of one random phase
   typedef enum logic [1:0] {
      MIX_GROW,
      MIX_SHRINK,
      MIX_BALANCED
   } mix_type;

   // fields of one response transaction
   typedef struct {
      logic [DOUT_W-1:0] data_out;
      logic [DOUT_W-1:0] front_value;
      logic [DOUT_W-1:0] back_value;
      logic [CNT_W-1:0]  count;
      logic              is_empty;
      logic [STAT_W-1:0] status;
   } list_result_type;

   // mirror of the list contents and the responses still owed by the block
   class list_tracker;
      logic [DIN_W-1:0] cells [LIST_DEPTH];
      int unsigned      used;
      list_result_type  results_due[$];
      int unsigned      failures;

      function new();
         used = 0;
         failures = 0;
         foreach (cells[i]) cells[i] = '0;
      endfunction

      // open a gap at index at and fill it
      function void put_at(int unsigned at, logic [DIN_W-1:0] value);
         for (int unsigned i = used; i > at; i--) cells[i] = cells[i-1];
         cells[at] = value;
         used++;
      endfunction

      // close the cell at index at and hand back its value
      function logic [DIN_W-1:0] take_at(int unsigned at);
         logic [DIN_W-1:0] value;
         value = cells[at];
         for (int unsigned i = at; i + 1 < used; i++) cells[i] = cells[i+1];
         used--;
         return value;
      endfunction

      function int unsigned outstanding();
         return results_due.size();
      endfunction

      // apply an accepted request to the mirror and queue its response
      function void note_command(logic [OP_W-1:0] op, logic [POS_W-1:0] pos,
                                 logic [DIN_W-1:0] din);
         list_result_type  res;
         logic             full;
         int unsigned      i;
         logic [DIN_W-1:0] swap_value;
         res.data_out = '0;
         res.status   = ST_OK;
         full = (used >= LIST_DEPTH);
         case (op)
            OP_PUSH_FRONT: begin
               if (full) res.status = ST_FULL;
               else put_at(0, din);
            end
            OP_POP_FRONT: begin
               if (used == 0) res.status = ST_RANGE;
               else res.data_out = take_at(0);
            end
            OP_PUSH_BACK: begin
               if (full) res.status = ST_FULL;
               else put_at(used, din);
            end
            OP_POP_BACK: begin
               if (used == 0) res.status = ST_RANGE;
               else res.data_out = take_at(used - 1);
            end
            OP_INSERT: begin
               if (pos > used) res.status = ST_RANGE;
               else if (full) res.status = ST_FULL;
               else put_at(pos, din);
            end
            OP_ERASE: begin
               if (pos >= used) res.status = ST_RANGE;
               else res.data_out = take_at(pos);
            end
            OP_READ: begin
               if (pos >= used) res.status = ST_RANGE;
               else res.data_out = cells[pos];
            end
            OP_READ_END: begin
               if (pos == 0 || pos > used) res.status = ST_RANGE;
               else res.data_out = cells[used - pos];
            end
            OP_REMOVE: begin
               if (used == 0) begin
                  res.status = ST_RANGE;
               end else begin
                  i = 0;
                  while (i < used && cells[i] != din) i++;
                  if (i < used) res.data_out = take_at(i);
                  else res.status = ST_MISSING;
               end
            end
            OP_REVERSE: begin
               for (i = 0; i < used / 2; i++) begin
                  swap_value = cells[i];
                  cells[i] = cells[used-1-i];
                  cells[used-1-i] = swap_value;
               end
            end
            default: begin
            end
         endcase
         res.front_value = (used != 0) ? cells[0] : '0;
         res.back_value  = (used != 0) ? cells[used-1] : '0;
         res.count       = CNT_W'(used);
         res.is_empty    = (used == 0);
         results_due.insert(results_due.size(), res);
      endfunction

      // compare one response transaction against the oldest one owed
      function void check_result(logic [RSP_TDATA_W-1:0] raw);
         list_result_type want;
         list_result_type got;
         got.data_out    = raw[DOUT_LSB +: DOUT_W];
         got.front_value = raw[FRONT_LSB +: DOUT_W];
         got.back_value  = raw[BACK_LSB +: DOUT_W];
         got.count       = raw[CNT_LSB +: CNT_W];
         got.is_empty    = raw[EMPTY_LSB];
         got.status      = raw[STAT_LSB +: STAT_W];
         if (results_due.size() == 0) begin
            failures++;
            if (failures <= MAX_REPORTS)
               $display("%0t: unexpected response data_out=%h count=%0d status=%0d",
                        $realtime, got.data_out, got.count, got.status);
            return;
         end
         want = results_due[0];
         results_due.delete(0);
         if (got.data_out !== want.data_out || got.front_value !== want.front_value ||
             got.back_value !== want.back_value || got.count !== want.count ||
             got.is_empty !== want.is_empty || got.status !== want.status) begin
            failures++;
            if (failures <= MAX_REPORTS) begin
               $display("%0t: response mismatch", $realtime);
               $display("   expected data_out=%h front=%h back=%h count=%0d empty=%b status=%0d",
                        want.data_out, want.front_value, want.back_value, want.count,
                        want.is_empty, want.status);
               $display("   actual   data_out=%h front=%h back=%h count=%0d empty=%b status=%0d",
                        got.data_out, got.front_value, got.back_value, got.count,
                        got.is_empty, got.status);
            end
         end
      endfunction
   endclass

   logic                   clock = 1'b0;
   logic                   reset;
   logic                   req_tvalid;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata;
   logic                   rsp_tvalid;
   logic                   rsp_tready;
   logic [RSP_TDATA_W-1:0] rsp_tdata;

   list_tracker tracker = new();
   mix_type     mix;
   bit          quiet;
   bit          hold_request;
   int unsigned hold_left;
   int unsigned rsp_idle_left;
   int unsigned idle_cycles;

   bounded_indexed_list i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #(CLOCK_PERIOD / 2.0) clock = ~clock;

   // idle length: mostly none, some short, a few long
   function automatic int unsigned pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // offer one request transaction and wait until the block takes it
   task automatic send_item(input logic [OP_W-1:0] op, input logic [POS_W-1:0] pos,
                            input logic [DIN_W-1:0] din);
      int unsigned            gap;
      logic [REQ_TDATA_W-1:0] word;
      gap = quiet ? 0 : pick_gap();
      word = '0;
      word[OP_LSB +: OP_W]   = op;
      word[POS_LSB +: POS_W] = pos;
      word[DIN_LSB +: DIN_W] = din;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= word;
      do @(posedge clock); while (!req_tready);
      tracker.note_command(op, pos, din);
      @(negedge clock);
   endtask

   // op weighted by the current phase mix
   function automatic logic [OP_W-1:0] pick_op();
      int unsigned r;
      int unsigned add_pct;
      int unsigned del_pct;
      r = $urandom_range(0, 99);
      case (mix)
         MIX_GROW:   begin add_pct = 70; del_pct = 12; end
         MIX_SHRINK: begin add_pct = 15; del_pct = 60; end
         default:    begin add_pct = 35; del_pct = 33; end
      endcase
      if (r < 2) return OP_W'($urandom_range(OP_FIRST_UNUSED, OP_LAST_UNUSED));
      if (r < 2 + add_pct) begin
         case ($urandom_range(0, 2))
            0:       return OP_PUSH_FRONT;
            1:       return OP_PUSH_BACK;
            default: return OP_INSERT;
         endcase
      end
      if (r < 2 + add_pct + del_pct) begin
         case ($urandom_range(0, 3))
            0:       return OP_POP_FRONT;
            1:       return OP_POP_BACK;
            2:       return OP_ERASE;
            default: return OP_REMOVE;
         endcase
      end
      case ($urandom_range(0, 2))
         0:       return OP_READ;
         1:       return OP_READ_END;
         default: return OP_REVERSE;
      endcase
   endfunction

   // value: a held element for removal most times, else a small pool or any word
   function automatic logic [DIN_W-1:0] pick_value(logic [OP_W-1:0] op);
      if (op == OP_REMOVE && tracker.used > 0 && $urandom_range(0, 9) < 7)
         return tracker.cells[$urandom_range(0, tracker.used - 1)];
      if ($urandom_range(0, 1) == 0) return DIN_W'($urandom_range(0, POOL_SIZE - 1));
      return $urandom;
   endfunction

   // response side ready pattern, with one long hold-off on request
   initial begin
      rsp_tready    = 1'b0;
      hold_left     = 0;
      rsp_idle_left = 0;
      forever begin
         @(negedge clock);
         if (hold_left > 0) begin
            rsp_tready <= 1'b0;
            hold_left--;
         end else if (hold_request) begin
            hold_request = 1'b0;
            hold_left = HOLD_CYCLES - 1;
            rsp_tready <= 1'b0;
         end else if (rsp_idle_left > 0) begin
            rsp_tready <= 1'b0;
            rsp_idle_left--;
         end else begin
            rsp_idle_left = quiet ? 0 : pick_gap();
            if (rsp_idle_left == 0) begin
               rsp_tready <= 1'b1;
            end else begin
               rsp_tready <= 1'b0;
               rsp_idle_left--;
            end
         end
      end
   end

   // check every response transaction
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) tracker.check_result(rsp_tdata);
   end

   // end the run when nothing moves for too long
   initial begin
      idle_cycles = 0;
      forever begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) idle_cycles = 0;
         else idle_cycles++;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
         end
      end
   end

   // stimulus and end of run
   initial begin
      logic [OP_W-1:0]  op;
      logic [POS_W-1:0] pos;
      reset        = 1'b1;
      req_tvalid   = 1'b0;
      req_tdata    = '0;
      hold_request = 1'b0;
      quiet        = 1'b0;
      mix          = MIX_BALANCED;
      repeat (RESET_CYCLES) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // empty list: every pop, index and search op fails, reverse and unused op are no-ops
      send_item(OP_POP_FRONT, 5'd0, 32'h0);
      send_item(OP_POP_BACK, 5'd0, 32'h0);
      send_item(OP_ERASE, 5'd0, 32'h0);
      send_item(OP_READ, 5'd0, 32'h0);
      send_item(OP_READ_END, 5'd1, 32'h0);
      send_item(OP_REMOVE, 5'd0, 32'h0);
      send_item(OP_REVERSE, 5'd0, 32'h0);
      send_item(OP_INSERT, 5'd1, 32'h1111_1111);
      send_item(OP_LAST_UNUSED, 5'd31, 32'hFFFF_FFFF);
      // build a short list, insert at the front and at the end, then past the end
      send_item(OP_PUSH_FRONT, 5'd0, 32'hFFFF_FFFF);
      send_item(OP_PUSH_BACK, 5'd0, 32'h0000_0000);
      send_item(OP_INSERT, 5'd0, 32'hA5A5_A5A5);
      send_item(OP_INSERT, 5'd3, 32'h5A5A_5A5A);
      send_item(OP_INSERT, 5'd5, 32'h2222_2222);
      // reads inside and outside the range, from both ends, then a reverse
      send_item(OP_READ, 5'd16, 32'h0);
      send_item(OP_READ, 5'd1, 32'h0);
      send_item(OP_READ_END, 5'd0, 32'h0);
      send_item(OP_READ_END, 5'd4, 32'h0);
      send_item(OP_READ_END, 5'd5, 32'h0);
      send_item(OP_REVERSE, 5'd0, 32'h0);
      // search hit and miss, erase in range and at the count, then a pop from each end
      send_item(OP_REMOVE, 5'd0, 32'h0000_0000);
      send_item(OP_REMOVE, 5'd0, 32'h1234_5678);
      send_item(OP_ERASE, 5'd1, 32'h0);
      send_item(OP_ERASE, 5'd2, 32'h0);
      send_item(OP_POP_FRONT, 5'd0, 32'h0);
      send_item(OP_POP_BACK, 5'd0, 32'h0);

      // random phases of growing, shrinking and mixed traffic
      for (int unsigned n = 0; n < RANDOM_ITEMS; n++) begin
         if (n % PHASE_ITEMS == 0) begin
            mix   = (n == 0) ? MIX_GROW : mix_type'($urandom_range(0, 2));
            quiet = ($urandom_range(0, 3) == 0);
         end
         if (n == HOLD_ITEM) begin
            quiet = 1'b1;
            hold_request = 1'b1;
         end
         op = pick_op();
         if ($urandom_range(0, 3) == 0) pos = POS_W'($urandom_range(0, LIST_DEPTH));
         else pos = POS_W'($urandom_range(0, tracker.used));
         send_item(op, pos, pick_value(op));
      end
      req_tvalid <= 1'b0;

      while (tracker.outstanding() > 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (tracker.failures == 0 && tracker.outstanding() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
